// ===== rtl/lpf_pkg.sv =====
// package for the led pulse fader: payload types, command and mode codes, sequencer states
`timescale 1ns / 1ps

package lpf_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] mode_in;
  } lpf_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lpf_out_t;

  localparam logic [1:0] FUNC_TICK      = 2'd0;
  localparam logic [1:0] FUNC_SET_MODE  = 2'd1;
  localparam logic [1:0] FUNC_PULSE     = 2'd2;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_LOOP = 2'd1;
  localparam logic [1:0] MODE_ONCE = 2'd2;

  localparam logic REG_BASE_COLOUR  = 1'b0;
  localparam logic REG_PULSE_LENGTH = 1'b1;

  localparam logic [23:0] BASE_COLOUR_RESET  = 24'hFF00FF;
  localparam logic [15:0] PULSE_LENGTH_RESET = 16'd100;

  localparam int QUOT_WIDTH = 8;
  localparam int PL_WIDTH   = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } lpf_state_t;

endpackage

// ===== rtl/led_pulse_fader_top.sv =====
// led pulse fader: triangle brightness ramp and colour scaling through one shared divider
//
//   channel  direction  handshake          word
//   in       input      in_valid/in_stall  lpf_in_t  (func, mode_in)
//   out      output     out_valid/out_stall lpf_out_t (red, green, blue)
//   cfg      input      psel/penable/pready base_colour at 0x0, pulse_length at 0x4
//
// a tick steps the ramp when it is taken, then per colour a multiply state and up
// to nine divider steps (the saturation check then one quotient bit a cycle), then
// the load into the output register. mode and single pulse commands are applied in
// the idle state. in_stall is high from the cycle after a tick is taken until its
// word is in the output register; a waiting output word holds the sequencer.
// rst_n is synchronous; reset gives magenta, pulse length 100, loop mode, level 0.
`timescale 1ns / 1ps

module led_pulse_fader_top #(
  parameter int LEVEL_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lpf_pkg::lpf_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lpf_pkg::lpf_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lpf_pkg::*;

  localparam int PRW = LEVEL_WIDTH + QUOT_WIDTH;
  localparam int CW  = (PRW > PL_WIDTH + QUOT_WIDTH) ? PRW : PL_WIDTH + QUOT_WIDTH;
  localparam int PW  = (LEVEL_WIDTH > PL_WIDTH) ? LEVEL_WIDTH : PL_WIDTH;

  lpf_state_t state_r, state_nxt;

  logic [23:0]            base_colour_r;
  logic [15:0]            pulse_length_r;
  logic [1:0]             mode_r, mode_nxt;
  logic                   falling_r, falling_nxt;
  logic [LEVEL_WIDTH-1:0] level_r, level_nxt;
  logic [1:0]             ch_r, ch_nxt;
  logic [3:0]             step_r, step_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic [7:0]             quot_r, quot_nxt;
  lpf_out_t               res_r, res_nxt;
  lpf_out_t               out_data_r;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_take;
  logic                   cfg_write;
  logic                   ch_done;
  logic                   out_load;
  logic [15:0]            divisor;
  logic [CW-1:0]          trial;
  logic                   rem_ge;
  logic [7:0]             chan;
  logic [PRW-1:0]         product;
  logic [PW-1:0]          lvl_ext;
  logic [PW-1:0]          pl_ext;
  logic [7:0]             quot_bit;

  // configuration port
  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_PULSE_LENGTH) ? {16'd0, pulse_length_r}
                                                    : {8'd0, base_colour_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_colour_r  <= BASE_COLOUR_RESET;
      pulse_length_r <= PULSE_LENGTH_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_BASE_COLOUR) begin
        base_colour_r <= pwdata[23:0];
      end else begin
        pulse_length_r <= pwdata[15:0];
      end
    end
  end

  // shared datapath pieces
  assign divisor = (pulse_length_r == '0) ? 16'd1 : pulse_length_r;
  assign trial   = CW'(divisor) << step_r;
  assign rem_ge  = (rem_r >= trial);
  assign product = PRW'(chan) * PRW'(level_r);
  assign lvl_ext = PW'(level_r);
  assign pl_ext  = PW'(pulse_length_r);

  always_comb begin
    case (ch_r)
      2'd0:    chan = base_colour_r[23:16];
      2'd1:    chan = base_colour_r[15:8];
      default: chan = base_colour_r[7:0];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.func == FUNC_TICK) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (ch_done) begin
          state_nxt = (ch_r == 2'd2) ? ST_OUT : ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    ch_done  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_MUL:  ch_done  = 1'b0;
      ST_DIV: begin
        ch_done = (step_r == 4'd0) || ((step_r == 4'd8) && rem_ge);
      end
      ST_OUT: out_load = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_take = in_valid & ~in_stall;

  // datapath next values
  always_comb begin
    mode_nxt      = mode_r;
    falling_nxt   = falling_r;
    level_nxt     = level_r;
    ch_nxt        = ch_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    quot_bit      = 8'd1 << step_r[2:0];

    if (in_take) begin
      case (in_data.func)
        FUNC_SET_MODE: mode_nxt = in_data.mode_in;
        FUNC_PULSE: begin
          mode_nxt    = MODE_ONCE;
          level_nxt   = '0;
          falling_nxt = 1'b0;
        end
        FUNC_TICK: begin
          ch_nxt = 2'd0;
          if (mode_r == MODE_LOOP || mode_r == MODE_ONCE) begin
            if (!falling_r) begin
              if (lvl_ext < pl_ext && level_r != '1) begin
                level_nxt = level_r + 1'b1;
              end else begin
                falling_nxt = 1'b1;
              end
            end else begin
              if (level_r != '0) begin
                level_nxt = level_r - 1'b1;
              end else begin
                falling_nxt = 1'b0;
                if (mode_r == MODE_ONCE) begin
                  mode_nxt = MODE_NONE;
                end
              end
            end
          end else begin
            // no-pulse mode, and the unused mode code, hold at the peak
            level_nxt = pl_ext[LEVEL_WIDTH-1:0];
          end
        end
        default: mode_nxt = mode_r;
      endcase
    end

    case (state_r)
      ST_MUL: begin
        rem_nxt  = CW'(product);
        quot_nxt = '0;
        step_nxt = 4'd8;
      end
      ST_DIV: begin
        if (step_r == 4'd8) begin
          // quotient of 256 or more saturates
          if (rem_ge) begin
            quot_nxt = 8'hFF;
          end
        end else if (rem_ge) begin
          rem_nxt  = rem_r - trial;
          quot_nxt = quot_r | quot_bit;
        end
        if (!ch_done) begin
          step_nxt = step_r - 4'd1;
        end else begin
          case (ch_r)
            2'd0:    res_nxt.red   = (step_r == 4'd8) ? 8'hFF : quot_nxt;
            2'd1:    res_nxt.green = (step_r == 4'd8) ? 8'hFF : quot_nxt;
            default: res_nxt.blue  = (step_r == 4'd8) ? 8'hFF : quot_nxt;
          endcase
          ch_nxt = ch_r + 2'd1;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: step_nxt = step_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_LOOP;
      falling_r   <= 1'b0;
      level_r     <= '0;
      ch_r        <= 2'd0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      falling_r   <= falling_nxt;
      level_r     <= level_nxt;
      ch_r        <= ch_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
